// ----- rtl/cisv_pkg.sv -----
`timescale 1ns / 1ps

package cisv_pkg;

   localparam int MAX_NEST_DEF = 32;
   localparam int CSR_W        = 6;
   localparam int CMP_W        = 7;
   localparam logic [CSR_W-1:0] CSR_RESET = 6'd32;

   localparam logic [4:0] AI_ARG1 = 5'd24;
   localparam logic [4:0] AI_RSVD = 5'd28;

   localparam logic [2:0] MAJ_BSTR  = 3'd2;
   localparam logic [2:0] MAJ_TSTR  = 3'd3;
   localparam logic [2:0] MAJ_ARRAY = 3'd4;
   localparam logic [2:0] MAJ_MAP   = 3'd5;
   localparam logic [2:0] MAJ_TAG   = 3'd6;

   localparam int FQ_DEPTH = 2;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OPEN = 2'd0,
      ST_DONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_HEAD    = 2'd0,
      PH_ARG     = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic {
      ENG_RUN = 1'b0,
      ENG_POP = 1'b1
   } eng_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [2:0] major;
      logic [4:0] ai;
      logic       ai_bad;
      logic       ai_imm;
      logic [3:0] arg_len;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } item_link_type;

   typedef struct packed {
      logic       push;
      logic [1:0] status;
   } rsp_push_type;

   typedef struct packed {
      logic [63:0] items_left;
      logic        pair_half;
      logic        is_map;
   } frame_type;

endpackage

// ----- rtl/cisv_front.sv -----
`timescale 1ns / 1ps

module cisv_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output cisv_pkg::item_link_type link,
   input  logic                   item_pop
);
   import cisv_pkg::*;

   req_item_type           q_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]       count_ff, count_in;
   req_item_type           cls;
   logic                   wr_en;
   logic                   rd_en;

   // head classification at entry
   always_comb begin
      cls.data_byte = req_data_byte;
      cls.last_byte = req_last_byte;
      cls.major     = req_data_byte[7:5];
      cls.ai        = req_data_byte[4:0];
      cls.ai_bad    = req_data_byte[4:0] >= AI_RSVD;
      cls.ai_imm    = req_data_byte[4:0] < AI_ARG1;
      cls.arg_len   = 4'(4'd1 << req_data_byte[1:0]);
   end

   assign req_full = count_ff == FQ_CW'(FQ_DEPTH);
   assign wr_en    = req_push && !req_full;
   assign rd_en    = item_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_en ? FQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? FQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = FQ_CW'(count_ff + 1'b1);
      end else if (rd_en && !wr_en) begin
         count_in = FQ_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assign link.valid = count_ff != '0;
   assign link.item  = q_ff[rd_ptr_ff];

endmodule

// ----- rtl/cisv_rspq.sv -----
`timescale 1ns / 1ps

module cisv_rspq (
   input  logic                  clock,
   input  logic                  reset,
   input  cisv_pkg::rsp_push_type push_in,
   output logic                  full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_status
);
   import cisv_pkg::*;

   logic [1:0]       q_ff [FQ_DEPTH];
   logic [FQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0] count_ff, count_in;
   logic             wr_en;
   logic             rd_en;

   assign full      = count_ff == FQ_CW'(FQ_DEPTH);
   assign rsp_empty = count_ff == '0;
   assign wr_en     = push_in.push && !full;
   assign rd_en     = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_en ? FQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? FQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = FQ_CW'(count_ff + 1'b1);
      end else if (rd_en && !wr_en) begin
         count_in = FQ_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= push_in.status;
      end
   end

   assign rsp_status = q_ff[rd_ptr_ff];

endmodule

// ----- rtl/cisv_back.sv -----
`timescale 1ns / 1ps

module cisv_back #(
   parameter int MAX_NEST = cisv_pkg::MAX_NEST_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cisv_pkg::item_link_type      link,
   output logic                         item_pop,
   output cisv_pkg::rsp_push_type       rsp_push,
   input  logic                         rsp_full,
   input  logic                         csr_valid,
   input  logic [cisv_pkg::CSR_W-1:0]   csr_max_nesting
);
   import cisv_pkg::*;

   localparam int OFW   = $clog2(MAX_NEST + 2);
   localparam int AW    = $clog2(MAX_NEST + 1);
   localparam int DEPTH = MAX_NEST + 1;

   phase_type         phase_ff, phase_in;
   eng_type           state_ff, state_in;
   logic [3:0]        arg_left_ff, arg_left_in;
   logic [2:0]        pend_major_ff, pend_major_in;
   logic [63:0]       arg_val_ff, arg_val_in;
   logic [63:0]       pay_left_ff, pay_left_in;
   logic [OFW-1:0]    open_ff, open_in;
   frame_type         top_ff, top_in;
   logic [CSR_W-1:0]  max_nest_ff;

   frame_type         mem [DEPTH];
   frame_type         rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   logic [CMP_W-1:0]  limit;
   req_item_type      it;
   logic              go;
   logic              ap_en;
   logic [2:0]        ap_major;
   logic [63:0]       ap_val;
   logic [63:0]       cnt;
   logic [63:0]       nv;
   logic [3:0]        nl;
   logic [63:0]       np;
   logic              do_close;
   logic              finish;
   status_type        st;
   frame_type         src;
   logic [63:0]       dec;

   assign it    = link.item;
   assign go    = link.valid && !rsp_full;
   assign limit = ({1'b0, max_nest_ff} < CMP_W'(MAX_NEST)) ? CMP_W'(max_nest_ff)
                                                            : CMP_W'(MAX_NEST);

   always_comb begin
      phase_in      = phase_ff;
      state_in      = state_ff;
      arg_left_in   = arg_left_ff;
      pend_major_in = pend_major_ff;
      arg_val_in    = arg_val_ff;
      pay_left_in   = pay_left_ff;
      open_in       = open_ff;
      top_in        = top_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = AW'(open_ff - 1'b1);
      ap_en         = 1'b0;
      ap_major      = it.major;
      ap_val        = {59'd0, it.ai};
      cnt           = '0;
      nv            = {arg_val_ff[55:0], it.data_byte};
      nl            = (arg_left_ff != 4'd0) ? 4'(arg_left_ff - 4'd1) : 4'd0;
      np            = (pay_left_ff != 64'd0) ? 64'(pay_left_ff - 64'd1) : 64'd0;
      do_close      = 1'b0;
      finish        = 1'b0;
      st            = ST_OPEN;
      src           = (state_ff == ENG_POP) ? rd_data_ff : top_ff;
      dec           = 64'(src.items_left - 64'd1);
      item_pop      = 1'b0;
      rsp_push      = '0;

      if (state_ff == ENG_POP) begin
         do_close = 1'b1;
      end else if (go) begin
         case (phase_ff)
            PH_HEAD: begin
               if (CMP_W'(open_ff) > limit || it.ai_bad) begin
                  st     = ST_BAD;
                  finish = 1'b1;
               end else if (it.ai_imm) begin
                  ap_en = 1'b1;
               end else begin
                  pend_major_in = it.major;
                  arg_val_in    = '0;
                  arg_left_in   = it.arg_len;
                  phase_in      = PH_ARG;
                  finish        = 1'b1;
               end
            end
            PH_ARG: begin
               arg_val_in  = nv;
               arg_left_in = nl;
               if (nl == 4'd0) begin
                  ap_en    = 1'b1;
                  ap_major = pend_major_ff;
                  ap_val   = nv;
               end else begin
                  finish = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               pay_left_in = np;
               if (np == 64'd0) begin
                  do_close = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
            default: begin
               st     = ST_BAD;
               finish = 1'b1;
            end
         endcase
      end

      if (ap_en) begin
         case (ap_major)
            MAJ_BSTR, MAJ_TSTR: begin
               if (ap_val == 64'd0) begin
                  do_close = 1'b1;
               end else begin
                  pay_left_in = ap_val;
                  phase_in    = PH_PAYLOAD;
                  finish      = 1'b1;
               end
            end
            MAJ_ARRAY, MAJ_MAP, MAJ_TAG: begin
               cnt = (ap_major == MAJ_TAG) ? 64'd1 : ap_val;
               if (cnt == 64'd0) begin
                  do_close = 1'b1;
               end else begin
                  wr_en            = open_ff != '0;
                  top_in.items_left = cnt;
                  top_in.pair_half = 1'b0;
                  top_in.is_map    = ap_major == MAJ_MAP;
                  open_in          = OFW'(open_ff + 1'b1);
                  phase_in         = PH_HEAD;
                  finish           = 1'b1;
               end
            end
            default: begin
               do_close = 1'b1;
            end
         endcase
      end

      // one nesting level per cycle
      if (do_close) begin
         phase_in = PH_HEAD;
         state_in = ENG_RUN;
         if (open_ff == '0) begin
            st     = ST_DONE;
            finish = 1'b1;
         end else if (src.is_map && !src.pair_half) begin
            top_in           = src;
            top_in.pair_half = 1'b1;
            finish           = 1'b1;
         end else if (dec != 64'd0) begin
            top_in.items_left = dec;
            top_in.pair_half = 1'b0;
            top_in.is_map    = src.is_map;
            finish           = 1'b1;
         end else begin
            open_in = OFW'(open_ff - 1'b1);
            if (open_ff == OFW'(1)) begin
               st     = ST_DONE;
               finish = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(open_ff - OFW'(2));
               state_in = ENG_POP;
            end
         end
      end

      if (finish) begin
         if (st == ST_OPEN && it.last_byte) begin
            st = ST_BAD;
         end
         if (st != ST_OPEN) begin
            phase_in      = PH_HEAD;
            arg_left_in   = '0;
            pend_major_in = '0;
            arg_val_in    = '0;
            pay_left_in   = '0;
            open_in       = '0;
         end
         state_in        = ENG_RUN;
         item_pop        = 1'b1;
         rsp_push.push   = 1'b1;
         rsp_push.status = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD;
         state_ff      <= ENG_RUN;
         arg_left_ff   <= '0;
         pend_major_ff <= '0;
         arg_val_ff    <= '0;
         pay_left_ff   <= '0;
         open_ff       <= '0;
         max_nest_ff   <= CSR_RESET;
      end else begin
         phase_ff      <= phase_in;
         state_ff      <= state_in;
         arg_left_ff   <= arg_left_in;
         pend_major_ff <= pend_major_in;
         arg_val_ff    <= arg_val_in;
         pay_left_ff   <= pay_left_in;
         open_ff       <= open_in;
         if (csr_valid) begin
            max_nest_ff <= csr_max_nesting;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // frames below the top one
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OFW'(MAX_NEST + 1))
      else $error("frame count beyond nesting depth");

   a_pop_has_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_POP |-> open_ff != '0)
      else $error("frame pop with no open frame");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push.push |-> !rsp_full && link.valid)
      else $error("status written without room or without a byte");

   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> rsp_push.push)
      else $error("byte retired without a status");

endmodule

// ----- rtl/cbor_item_skip_validator.sv -----
`timescale 1ns / 1ps

// cbor item skip validator
// req channel: one byte of the encoded stream per transfer, with req_last_byte
//   marking the end of the buffer; a transfer happens when req_push is high and
//   req_full is low
// rsp channel: one status per input byte, in order (0 item open, 1 top-level
//   item complete, 2 invalid); the oldest status is on rsp_status while
//   rsp_empty is low and leaves on rsp_pop
// csr channel: csr_max_nesting sets the deepest accepted nesting level; ready
//   is always high, write only while the block is idle
// status path: a byte waits in the registered byte queue and its status in the
//   registered status queue; closing nested containers adds a pop of each level
//   off the frame memory, as that memory has a registered read port
// throughput: one byte per cycle while rsp_full is low and no level is popped
// reset: decoding returns to awaiting a head, both queues empty, max nesting 32
// a stalled rsp side fills the two-entry status queue and then the two-entry
//   byte queue, after which req_full rises; nothing is dropped
module cbor_item_skip_validator #(
   parameter int MAX_NEST = cisv_pkg::MAX_NEST_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [1:0]                 rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [cisv_pkg::CSR_W-1:0] csr_max_nesting
);
   import cisv_pkg::*;

   item_link_type link;
   logic          item_pop;
   rsp_push_type  rsp_push;
   logic          rsp_full;

   assign csr_ready = 1'b1;

   cisv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .link          (link),
      .item_pop      (item_pop)
   );

   cisv_back #(
      .MAX_NEST (MAX_NEST)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .link            (link),
      .item_pop        (item_pop),
      .rsp_push        (rsp_push),
      .rsp_full        (rsp_full),
      .csr_valid       (csr_valid),
      .csr_max_nesting (csr_max_nesting)
   );

   cisv_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push_in    (rsp_push),
      .full       (rsp_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_status (rsp_status)
   );

endmodule
